>>> rtl/mandelbrot_escape_time_pixel_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time pixel core
// Two concurrent property forms used by the iteration sequencer.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define METP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset
`define METP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/metp_pkg.sv
// ----------------------------------------------------------------------------
// Escape-time pixel core package
// Types, constants and helper functions shared by the core's modules.
// ----------------------------------------------------------------------------
package metp_pkg;

   // Fixed-point format of the complex coordinates (signed Q6.26)
   localparam int COORD_BITS    = 32;
   localparam int FRACTION_BITS = 26;
   localparam int PROD_BITS     = 2 * COORD_BITS;
   localparam int SUM_BITS      = PROD_BITS + 1;
   localparam int STEP_BITS     = 31;
   localparam int COUNT_BITS    = 8;
   localparam int COLUMN_BITS   = 7;
   localparam int ROW_BITS      = 5;

   // Register port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   // Escape threshold: magnitude squared of 4 at twice the fraction bits
   localparam logic [PROD_BITS-1:0] ESCAPE_LIMIT =
      PROD_BITS'(4) << (2 * FRACTION_BITS);

   // Register reset values
   localparam coord_type              MIN_REAL_RESET  = -32'sd268435456;
   localparam logic [STEP_BITS-1:0]   REAL_STEP_RESET = 31'd3145728;
   localparam coord_type              MIN_IMAG_RESET  = -32'sd67108864;
   localparam logic [STEP_BITS-1:0]   IMAG_STEP_RESET = 31'd4194304;
   localparam logic [COUNT_BITS-1:0]  MAX_ITER_RESET  = 8'd20;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIN_REAL       = 3'd0,
      CSR_REAL_STEP      = 3'd1,
      CSR_MIN_IMAG       = 3'd2,
      CSR_IMAG_STEP      = 3'd3,
      CSR_MAX_ITERATIONS = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_RE,
      ST_MAP_IM,
      ST_LOAD,
      ST_MUL_RR,
      ST_MUL_II,
      ST_TEST,
      ST_UPDATE,
      ST_DONE
   } metp_state_type;

   typedef struct packed {
      coord_type              min_real;
      logic [STEP_BITS-1:0]   real_step;
      coord_type              min_imag;
      logic [STEP_BITS-1:0]   imag_step;
      logic [COUNT_BITS-1:0]  max_iterations;
   } metp_cfg_type;

   typedef struct packed {
      logic [COLUMN_BITS-1:0] pixel_column;
      logic [ROW_BITS-1:0]    pixel_row;
   } metp_req_type;

   typedef struct packed {
      logic [COLUMN_BITS-1:0] column_out;
      logic [ROW_BITS-1:0]    row_out;
      logic [COUNT_BITS-1:0]  escape_count;
      logic                   pixel_on;
   } metp_rsp_type;

   // Clamp a wide sum to the signed coordinate range
   function automatic coord_type sat_coord(input sum_type v);
      logic [SUM_BITS-COORD_BITS:0] upper;
      upper = v[SUM_BITS-1:COORD_BITS-1];
      if ((&upper) || !(|upper)) begin
         return v[COORD_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         return COORD_MIN;
      end else begin
         return COORD_MAX;
      end
   endfunction

endpackage

>>> rtl/metp_mul.sv
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One coordinate-wide signed multiply a cycle, full product registered.
// ----------------------------------------------------------------------------
module metp_mul
   import metp_pkg::*;
(
   input  logic      clock,
   input  coord_type op_a,
   input  coord_type op_b,
   output prod_type  prod
);

   prod_type prod_ff;
   prod_type prod_in;

   // Form the exact product
   always_comb begin
      prod_in = op_a * op_b;
   end

   // Register the product for the sequencer
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> rtl/metp_iter.sv
// ----------------------------------------------------------------------------
// Escape-time sequencer
// Maps a pixel to c and runs z = z*z + c on the shared multiplier.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_core_defines.svh"

module metp_iter
   import metp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  metp_cfg_type cfg,
   input  logic         req_valid,
   output logic         req_ready,
   input  metp_req_type req_data,
   output logic         result_valid,
   input  logic         result_taken,
   output metp_rsp_type result
);

   metp_state_type state_ff, state_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   coord_type              cre_ff, cre_in;
   coord_type              cim_ff, cim_in;
   coord_type              re_ff, re_in;
   coord_type              im_ff, im_in;
   prod_type               rr_ff, rr_in;
   prod_type               diff_ff, diff_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   coord_type              op_a;
   coord_type              op_b;
   prod_type               prod;
   coord_type              map_base;
   coord_type              map_sat;
   logic [PROD_BITS:0]     mag_sum;
   logic                   escape;
   coord_type              re_next;
   coord_type              im_next;
   logic [COUNT_BITS-1:0]  count_inc;

   metp_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // Select multiplier operands for the current step
   always_comb begin
      op_a = re_ff;
      op_b = im_ff;
      case (state_ff)
         ST_MAP_RE: begin
            op_a = coord_type'(col_ff);
            op_b = coord_type'(cfg.real_step);
         end
         ST_MAP_IM: begin
            op_a = coord_type'(row_ff);
            op_b = coord_type'(cfg.imag_step);
         end
         ST_MUL_RR: begin
            op_a = re_ff;
            op_b = re_ff;
         end
         ST_MUL_II: begin
            op_a = im_ff;
            op_b = im_ff;
         end
         default: begin
            op_a = re_ff;
            op_b = im_ff;
         end
      endcase
   end

   // Datapath arithmetic on the registered product
   always_comb begin
      map_base  = (state_ff == ST_LOAD) ? cfg.min_imag : cfg.min_real;
      map_sat   = sat_coord(sum_type'(map_base) + sum_type'(prod));
      mag_sum   = {1'b0, rr_ff} + {1'b0, prod};
      escape    = mag_sum > {1'b0, ESCAPE_LIMIT};
      re_next   = sat_coord(sum_type'(diff_ff >>> FRACTION_BITS) + sum_type'(cre_ff));
      im_next   = sat_coord(sum_type'(prod >>> (FRACTION_BITS - 1)) + sum_type'(cim_ff));
      count_inc = count_ff + 1'b1;
   end

   // Next state and register updates
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      cre_in   = cre_ff;
      cim_in   = cim_ff;
      re_in    = re_ff;
      im_in    = im_ff;
      rr_in    = rr_ff;
      diff_in  = diff_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            col_in = req_data.pixel_column;
            row_in = req_data.pixel_row;
            if (req_valid) begin
               state_in = ST_MAP_RE;
            end
         end
         ST_MAP_RE: begin
            state_in = ST_MAP_IM;
         end
         ST_MAP_IM: begin
            cre_in   = map_sat;
            re_in    = map_sat;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cim_in   = map_sat;
            im_in    = map_sat;
            count_in = '0;
            state_in = (cfg.max_iterations == '0) ? ST_DONE : ST_MUL_RR;
         end
         ST_MUL_RR: begin
            state_in = ST_MUL_II;
         end
         ST_MUL_II: begin
            rr_in    = prod;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            diff_in  = rr_ff - prod;
            state_in = escape ? ST_DONE : ST_UPDATE;
         end
         ST_UPDATE: begin
            re_in    = re_next;
            im_in    = im_next;
            count_in = count_inc;
            state_in = (count_inc == cfg.max_iterations) ? ST_DONE : ST_MUL_RR;
         end
         ST_DONE: begin
            if (result_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      row_ff   <= row_in;
      cre_ff   <= cre_in;
      cim_ff   <= cim_in;
      re_ff    <= re_in;
      im_ff    <= im_in;
      rr_ff    <= rr_in;
      diff_ff  <= diff_in;
      count_ff <= count_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign result_valid        = (state_ff == ST_DONE);
   assign result.column_out   = col_ff;
   assign result.row_out      = row_ff;
   assign result.escape_count = count_ff;
   assign result.pixel_on     = (count_ff != cfg.max_iterations);

   // Hold a finished result until the output stage takes it
   `METP_ASSERT_NEXT(a_done_hold, clock, reset, state_ff == ST_DONE && !result_taken, state_ff == ST_DONE && $stable(count_ff), "finished result lost before hand-off")
   // Advance the count by exactly one per completed step
   `METP_ASSERT_NEXT(a_count_step, clock, reset, state_ff == ST_UPDATE, count_ff == COUNT_BITS'($past(count_ff) + 1'b1), "step count did not advance by one")
   // Drop straight to the result once the point escapes
   `METP_ASSERT_NEXT(a_escape_done, clock, reset, state_ff == ST_TEST && escape, state_ff == ST_DONE && $stable(count_ff), "escaped point did not finish")

endmodule

>>> rtl/mandelbrot_escape_time_pixel_core.sv
// Sequence: the pixel is mapped to c (MAP_RE, MAP_IM, LOAD), then each step runs
// re*re, im*im, re*im and the update in turn until the limit M is reached or the
// point escapes. Throughput: one request at a time; the next is taken only after
// the result has been handed to the output register.
// Reset: synchronous, active high; registers return to their default view
// and the core comes up idle with no result pending.
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel core
// Register bank, iteration sequencer and output register for one pixel.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core
   import metp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  metp_req_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output metp_rsp_type              rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   metp_cfg_type cfg_ff, cfg_in;
   logic         rsp_valid_ff, rsp_valid_in;
   metp_rsp_type rsp_data_ff, rsp_data_in;

   logic         result_valid;
   logic         result_taken;
   metp_rsp_type result;

   // Decode register writes; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_REAL:       cfg_in.min_real       = coord_type'(csr_wdata);
            CSR_REAL_STEP:      cfg_in.real_step      = csr_wdata[STEP_BITS-1:0];
            CSR_MIN_IMAG:       cfg_in.min_imag       = coord_type'(csr_wdata);
            CSR_IMAG_STEP:      cfg_in.imag_step      = csr_wdata[STEP_BITS-1:0];
            CSR_MAX_ITERATIONS: cfg_in.max_iterations = csr_wdata[COUNT_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_real       <= MIN_REAL_RESET;
         cfg_ff.real_step      <= REAL_STEP_RESET;
         cfg_ff.min_imag       <= MIN_IMAG_RESET;
         cfg_ff.imag_step      <= IMAG_STEP_RESET;
         cfg_ff.max_iterations <= MAX_ITER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   metp_iter u_iter (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .result_valid (result_valid),
      .result_taken (result_taken),
      .result       (result)
   );

   // Take a finished result whenever the output register is free
   always_comb begin
      result_taken = result_valid && (!rsp_valid_ff || rsp_ready);
      rsp_data_in  = result_taken ? result : rsp_data_ff;
      if (result_taken) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
